// File: src/swtm_pkg.sv
// Package for the sliding-window throughput meter: widths, constants and shared types.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package swtm_pkg;

   // Ring geometry.
   localparam int WINDOW  = 128;
   localparam int SLOT_W  = $clog2(WINDOW);

   // Field widths.
   localparam int BYTES_W = 16;
   localparam int TIME_W  = 32;
   localparam int RATE_W  = 34;

   // The running sum must hold WINDOW full-size packets.
   localparam int SUM_W   = $clog2(WINDOW * 65535 + 1);

   // Bytes per microsecond times 8 bits times 256 for the Q.8 fraction.
   localparam int RATE_SHIFT = 11;

   // Dividend width of the serial divider, never narrower than the result.
   localparam int DIV_W  = (SUM_W + RATE_SHIFT > RATE_W) ? SUM_W + RATE_SHIFT : RATE_W;
   localparam int DCNT_W = $clog2(DIV_W + 1);

   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};

   // Queue between the front and the back.
   localparam int Q_DEPTH = 2;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [BYTES_W-1:0] bytes;
      logic [TIME_W-1:0]  arrival;
   } q_item_type;

   typedef struct packed {
      logic       valid;
      q_item_type item;
   } q_head_type;

   typedef struct packed {
      logic             start;
      logic [DIV_W-1:0] dividend;
      logic [TIME_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [DIV_W-1:0] quotient;
   } div_rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_DIVST,
      ST_DIVW,
      ST_FIN
   } back_state_type;

endpackage

// File: src/swtm_ifs.sv
// Handshake interfaces for the request and response channels of the meter.
// Depends on swtm_pkg for the field widths.
`timescale 1ns / 1ps

interface swtm_req_if;
   import swtm_pkg::*;

   logic               valid;
   logic               ready;
   logic [BYTES_W-1:0] packet_bytes;
   logic [TIME_W-1:0]  arrival_time_us;

   modport source (output valid, packet_bytes, arrival_time_us, input ready);
   modport sink   (input valid, packet_bytes, arrival_time_us, output ready);
endinterface

interface swtm_rsp_if;
   import swtm_pkg::*;

   logic              valid;
   logic              ready;
   logic [RATE_W-1:0] rate_mbps_q8;
   logic [TIME_W-1:0] window_interval_us;
   logic              zero_interval;

   modport source (output valid, rate_mbps_q8, window_interval_us, zero_interval,
                   input ready);
   modport sink   (input valid, rate_mbps_q8, window_interval_us, zero_interval,
                   output ready);
endinterface

// File: src/swtm_front.sv
// Front end of the meter: accepts request items into a short queue for the back end.
// Depends on swtm_pkg and the request interface in swtm_ifs.
`timescale 1ns / 1ps

module swtm_front (
   input  logic                clock,
   input  logic                reset,
   swtm_req_if.sink            req_ch,
   output swtm_pkg::q_head_type head,
   input  logic                pop
);
   import swtm_pkg::*;

   q_item_type         entry_ff [Q_DEPTH];
   logic [Q_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [Q_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [Q_CNT_W-1:0] count_ff,  count_in;
   logic               push;

   // Accept while there is room in the queue.
   assign req_ch.ready = (count_ff != Q_CNT_W'(Q_DEPTH));
   assign push         = req_ch.valid && req_ch.ready;

   assign head.valid = (count_ff != '0);
   assign head.item  = entry_ff[rd_ptr_ff];

   // Pointer and fill count updates.
   always_comb begin
      rd_ptr_in = rd_ptr_ff;
      wr_ptr_in = wr_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ptr_ff <= '0;
         wr_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         rd_ptr_ff <= rd_ptr_in;
         wr_ptr_ff <= wr_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage holds payload only.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff].bytes   <= req_ch.packet_bytes;
         entry_ff[wr_ptr_ff].arrival <= req_ch.arrival_time_us;
      end
   end

endmodule

// File: src/swtm_div.sv
// Restoring serial divider for the meter, one quotient bit per cycle.
// Depends on swtm_pkg for widths and the request and response structs.
`timescale 1ns / 1ps

module swtm_div (
   input  logic                 clock,
   input  logic                 reset,
   input  swtm_pkg::div_req_type div_req,
   output swtm_pkg::div_rsp_type div_rsp
);
   import swtm_pkg::*;

   logic [TIME_W-1:0] rem_ff,  rem_in;
   logic [DIV_W-1:0]  quo_ff,  quo_in;
   logic [TIME_W-1:0] dvs_ff;
   logic [DCNT_W-1:0] cnt_ff,  cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [TIME_W:0]   shifted;
   logic [TIME_W:0]   diff;
   logic              fits;

   // One step: shift in the next dividend bit and subtract if the divisor fits.
   assign shifted = {rem_ff, quo_ff[DIV_W-1]};
   assign diff    = shifted - {1'b0, dvs_ff};
   assign fits    = (shifted >= {1'b0, dvs_ff});

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         quo_in  = div_req.dividend;
         cnt_in  = DCNT_W'(DIV_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
         quo_in = {quo_ff[DIV_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DCNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers need no reset.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      if (div_req.start) begin
         dvs_ff <= div_req.divisor;
      end
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

   // A start always begins a division on the next cycle.
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_req.start |=> busy_ff)
      else $error("divider did not go busy after start");

   // Completion is flagged only once the step sequence has ended.
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff && $past(busy_ff))
      else $error("divider done without a finished run");

   // A running division always has steps left.
   a_busy_cnt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff != '0)
      else $error("divider busy with zero step count");

endmodule

// File: src/swtm_back.sv
// Back end of the meter: ring update, running byte sum, interval and rate sequencing.
// Depends on swtm_pkg, the response interface in swtm_ifs and the swtm_div unit.
`timescale 1ns / 1ps

module swtm_back (
   input  logic                clock,
   input  logic                reset,
   input  swtm_pkg::q_head_type head,
   output logic                pop,
   swtm_rsp_if.source          rsp_ch
);
   import swtm_pkg::*;

   // Ring memories. Unwritten slots are masked to zero through the fill state.
   logic [BYTES_W-1:0] size_mem [WINDOW];
   logic [TIME_W-1:0]  time_mem [WINDOW];

   back_state_type     state_ff, state_in;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SLOT_W-1:0]  slot_next;
   logic               wrapped_ff;
   logic [SUM_W-1:0]   sum_ff;

   logic [BYTES_W-1:0] bytes_ff;
   logic [TIME_W-1:0]  now_ff;
   logic [BYTES_W-1:0] old_size_ff;
   logic [TIME_W-1:0]  old_time_ff;
   logic               size_ok_ff;
   logic               time_ok_ff;
   logic [TIME_W-1:0]  interval_ff;
   logic [RATE_W-1:0]  rate_res_ff;
   logic               zero_res_ff;

   logic               out_valid_ff;
   logic [RATE_W-1:0]  out_rate_ff;
   logic [TIME_W-1:0]  out_interval_ff;
   logic               out_zero_ff;

   logic               load_out;
   logic [BYTES_W-1:0] old_size;
   logic [TIME_W-1:0]  old_time;
   logic [RATE_W-1:0]  rate_sat;
   div_req_type        div_req;
   div_rsp_type        div_rsp;

   assign slot_next = (slot_ff == SLOT_W'(WINDOW - 1)) ? '0 : slot_ff + 1'b1;
   assign old_size  = size_ok_ff ? old_size_ff : '0;
   assign old_time  = time_ok_ff ? old_time_ff : '0;

   // Saturate the quotient to the result width.
   assign rate_sat = (div_rsp.quotient > DIV_W'(RATE_MAX)) ? RATE_MAX
                                                          : div_rsp.quotient[RATE_W-1:0];

   swtm_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // Sequencer: next state and control strobes.
   always_comb begin
      state_in         = state_ff;
      pop              = 1'b0;
      div_req.start    = 1'b0;
      div_req.dividend = DIV_W'({sum_ff, {RATE_SHIFT{1'b0}}});
      div_req.divisor  = interval_ff;
      load_out         = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid) begin
               pop      = 1'b1;
               state_in = ST_CALC;
            end
         end
         ST_CALC: begin
            state_in = ST_DIVST;
         end
         ST_DIVST: begin
            if (interval_ff == '0) begin
               state_in = ST_FIN;
            end else begin
               div_req.start = 1'b1;
               state_in      = ST_DIVW;
            end
         end
         ST_DIVW: begin
            if (div_rsp.done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!out_valid_ff || rsp_ch.ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Ring state: write pointer, first-pass marker and the running byte sum.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_ff    <= '0;
         wrapped_ff <= 1'b0;
         sum_ff     <= '0;
      end else begin
         if (pop) begin
            slot_ff <= slot_next;
            if (slot_ff == SLOT_W'(WINDOW - 1)) begin
               wrapped_ff <= 1'b1;
            end
         end
         if (state_ff == ST_CALC) begin
            sum_ff <= sum_ff - SUM_W'(old_size) + SUM_W'(bytes_ff);
         end
      end
   end

   // Ring memories: read the displaced length and the oldest time, write the new item.
   always_ff @(posedge clock) begin
      if (pop) begin
         old_size_ff       <= size_mem[slot_ff];
         old_time_ff       <= time_mem[slot_next];
         size_mem[slot_ff] <= head.item.bytes;
         time_mem[slot_ff] <= head.item.arrival;
      end
   end

   // Working registers of the item in progress.
   always_ff @(posedge clock) begin
      if (pop) begin
         bytes_ff   <= head.item.bytes;
         now_ff     <= head.item.arrival;
         size_ok_ff <= wrapped_ff;
         time_ok_ff <= wrapped_ff || (slot_ff == SLOT_W'(WINDOW - 1));
      end
      if (state_ff == ST_CALC) begin
         interval_ff <= now_ff - old_time;
      end
      if (state_ff == ST_DIVST) begin
         rate_res_ff <= RATE_MAX;
         zero_res_ff <= (interval_ff == '0);
      end
      if (state_ff == ST_DIVW && div_rsp.done) begin
         rate_res_ff <= rate_sat;
      end
   end

   // Output register decouples the result from the next item's work.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_out) begin
         out_rate_ff     <= rate_res_ff;
         out_interval_ff <= interval_ff;
         out_zero_ff     <= zero_res_ff;
      end
   end

   assign rsp_ch.valid              = out_valid_ff;
   assign rsp_ch.rate_mbps_q8       = out_rate_ff;
   assign rsp_ch.window_interval_us = out_interval_ff;
   assign rsp_ch.zero_interval      = out_zero_ff;

   // The divider is never started on a zero interval.
   a_no_div_zero: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> interval_ff != '0)
      else $error("division started with a zero interval");

   // A flagged result carries the saturated rate and a zero interval.
   a_zero_result: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_zero_ff |-> out_rate_ff == RATE_MAX && out_interval_ff == '0)
      else $error("zero interval flag with inconsistent result");

   // While waiting for a quotient, the divider is running or has just finished.
   a_wait_div: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIVW |-> div_rsp.busy || div_rsp.done)
      else $error("waiting on an idle divider");

endmodule

// File: src/sliding_window_throughput_meter_core.sv
// Sliding-window throughput meter: one result per request item.
// An item passes the queue, the back-end states and the output register to give a result.
// The back end holds one item at a time and skips the 34-step divider on a zero interval.
// A two-entry front queue and the output register let both channels stall independently.
// Synchronous reset clears the rings logically (unwritten slots read as zero), the byte sum,
// the write slot, the queue and the output valid; no clearing pass is needed.
`timescale 1ns / 1ps

module sliding_window_throughput_meter_core (
   input  logic       clock,
   input  logic       reset,
   swtm_req_if.sink   req_ch,
   swtm_rsp_if.source rsp_ch
);
   import swtm_pkg::*;

   q_head_type head;
   logic       pop;

   // Front end accepts and queues request items.
   swtm_front u_front (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .head   (head),
      .pop    (pop)
   );

   // Back end updates the window and computes the rate.
   swtm_back u_back (
      .clock  (clock),
      .reset  (reset),
      .head   (head),
      .pop    (pop),
      .rsp_ch (rsp_ch)
   );

endmodule
